// File: hw/rtl/swc_pkg.sv
`default_nettype none

package swc_pkg;

  // Field widths
  localparam int ADC_W      = 24;
  localparam int NET_W      = ADC_W + 1;
  localparam int GAIN_W     = 32;
  localparam int WT_W       = 20;
  localparam int STEP_W     = 7;
  localparam int MIN_W      = 8;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;

  // Converter resolution actually used
  localparam int ADC_BITS = 24;
  localparam logic [ADC_W-1:0] ADC_MASK = (ADC_BITS >= ADC_W) ? {ADC_W{1'b1}} :
                                          ADC_W'((64'd1 << ADC_BITS) - 64'd1);

  // Shown weight above which a negative load flags overload
  localparam int NEG_FULL_LIMIT = 20;

  localparam logic [WT_W-1:0] WT_MAX = {WT_W{1'b1}};

  // Scaling: Q8.24 gain, round half up
  localparam int FRAC_W    = 24;
  localparam int GPROD_W   = ADC_W + GAIN_W;
  localparam int NPROD_W   = NET_W + GAIN_W;
  localparam int GROSS_W_W = GPROD_W - FRAC_W;
  localparam int NETW_W    = NPROD_W - FRAC_W;

  // Step rounding by reciprocal multiply; exact for values below 2^V_W
  localparam int V_W         = WT_W + 1;
  localparam int Q_W         = V_W;
  localparam int RECIP_SHIFT = 28;
  localparam int M_W         = 27;
  localparam int QPROD_W     = V_W + M_W;
  localparam int REM_W       = 7;

  localparam logic [M_W-1:0] RECIP_5   = M_W'((2**RECIP_SHIFT + 4) / 5);
  localparam logic [M_W-1:0] RECIP_10  = M_W'((2**RECIP_SHIFT + 9) / 10);
  localparam logic [M_W-1:0] RECIP_20  = M_W'((2**RECIP_SHIFT + 19) / 20);
  localparam logic [M_W-1:0] RECIP_50  = M_W'((2**RECIP_SHIFT + 49) / 50);
  localparam logic [M_W-1:0] RECIP_100 = M_W'((2**RECIP_SHIFT + 99) / 100);

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_LEVEL  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARE_LEVEL  = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPLIT_LEVEL = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_LOW    = 8'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_HIGH   = 8'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SIZE   = 8'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_DISP_MIN    = 8'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_OVL_LIMIT   = 8'd7;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_ONE     = 32'h0100_0000;
  localparam logic [STEP_W-1:0] STEP_RST     = 7'd1;
  localparam logic [MIN_W-1:0]  DISP_MIN_RST = 8'd2;
  localparam logic [WT_W-1:0]   OVL_RST      = 20'd60000;

  // Display step values with a rounding rule
  localparam logic [STEP_W-1:0] STEP_VAL_2   = 7'd2;
  localparam logic [STEP_W-1:0] STEP_VAL_5   = 7'd5;
  localparam logic [STEP_W-1:0] STEP_VAL_10  = 7'd10;
  localparam logic [STEP_W-1:0] STEP_VAL_20  = 7'd20;
  localparam logic [STEP_W-1:0] STEP_VAL_50  = 7'd50;
  localparam logic [STEP_W-1:0] STEP_VAL_100 = 7'd100;

  typedef enum logic [2:0] {
    STEP_PASS,
    STEP_2,
    STEP_5,
    STEP_10,
    STEP_20,
    STEP_50,
    STEP_100
  } swc_step_t;

  typedef struct packed {
    logic [ADC_W-1:0]  zero_level;
    logic [ADC_W-1:0]  tare_level;
    logic [ADC_W-1:0]  split_level;
    logic [GAIN_W-1:0] gain_low;
    logic [GAIN_W-1:0] gain_high;
    logic [STEP_W-1:0] step_size;
    logic [MIN_W-1:0]  display_min_steps;
    logic [WT_W-1:0]   overload_limit;
  } swc_cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [ADC_W-1:0] gross_c;
    logic [NET_W-1:0] net_c;
    logic             use_high;
    logic             positive;
    logic             stable;
  } swc_item_t;

  function automatic swc_step_t step_decode(input logic [STEP_W-1:0] step);
    swc_step_t kind;
    unique case (step)
      STEP_VAL_2:   kind = STEP_2;
      STEP_VAL_5:   kind = STEP_5;
      STEP_VAL_10:  kind = STEP_10;
      STEP_VAL_20:  kind = STEP_20;
      STEP_VAL_50:  kind = STEP_50;
      STEP_VAL_100: kind = STEP_100;
      default:      kind = STEP_PASS;
    endcase
    return kind;
  endfunction

  // Divisor of the rounding rule
  function automatic logic [STEP_W-1:0] step_div(input swc_step_t kind);
    logic [STEP_W-1:0] d;
    unique case (kind)
      STEP_10:  d = STEP_VAL_10;
      STEP_20:  d = STEP_VAL_20;
      STEP_50:  d = STEP_VAL_50;
      STEP_100: d = STEP_VAL_100;
      default:  d = STEP_VAL_5;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/swc_in_if.sv
`default_nettype none

interface swc_in_if;
  logic                      valid;
  logic                      ready;
  logic [swc_pkg::ADC_W-1:0] adc_average;
  logic                      is_stable;

  modport source (output valid, output adc_average, output is_stable, input ready);
  modport sink   (input valid, input adc_average, input is_stable, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/swc_out_if.sv
`default_nettype none

interface swc_out_if;
  logic                     valid;
  logic                     ready;
  logic [swc_pkg::WT_W-1:0] gross_weight;
  logic [swc_pkg::WT_W-1:0] shown_weight;
  logic                     is_positive;
  logic                     at_zero;
  logic                     overloaded;

  modport source (output valid, output gross_weight, output shown_weight,
                  output is_positive, output at_zero, output overloaded, input ready);
  modport sink   (input valid, input gross_weight, input shown_weight,
                  input is_positive, input at_zero, input overloaded, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/swc_cfg_if.sv
`default_nettype none

interface swc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swc_pkg::CFG_ADDR_W-1:0] addr;
  logic [swc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/swc_cfg_regs.sv
`default_nettype none

module swc_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  swc_cfg_if.sink                cfg_ch,
  output swc_pkg::swc_cfg_t      cfg
);
  import swc_pkg::*;

  swc_cfg_t regs_r;
  swc_cfg_t regs_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = regs_r;

  // Decode the write index; unknown indexes drop the write
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_ZERO_LEVEL:  regs_nxt.zero_level        = cfg_ch.data[ADC_W-1:0];
        CFG_TARE_LEVEL:  regs_nxt.tare_level        = cfg_ch.data[ADC_W-1:0];
        CFG_SPLIT_LEVEL: regs_nxt.split_level       = cfg_ch.data[ADC_W-1:0];
        CFG_GAIN_LOW:    regs_nxt.gain_low          = cfg_ch.data[GAIN_W-1:0];
        CFG_GAIN_HIGH:   regs_nxt.gain_high         = cfg_ch.data[GAIN_W-1:0];
        CFG_STEP_SIZE:   regs_nxt.step_size         = cfg_ch.data[STEP_W-1:0];
        CFG_DISP_MIN:    regs_nxt.display_min_steps = cfg_ch.data[MIN_W-1:0];
        CFG_OVL_LIMIT:   regs_nxt.overload_limit    = cfg_ch.data[WT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.zero_level        <= '0;
      regs_r.tare_level        <= '0;
      regs_r.split_level       <= '0;
      regs_r.gain_low          <= GAIN_ONE;
      regs_r.gain_high         <= GAIN_ONE;
      regs_r.step_size         <= STEP_RST;
      regs_r.display_min_steps <= DISP_MIN_RST;
      regs_r.overload_limit    <= OVL_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/swc_front.sv
`default_nettype none

module swc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire swc_pkg::swc_cfg_t cfg,
  swc_in_if.sink                 in_ch,
  output logic                   item_valid,
  output swc_pkg::swc_item_t     item,
  input  wire logic              item_ready
);
  import swc_pkg::*;

  logic                 valid_r;
  swc_item_t            item_r;
  swc_item_t            item_nxt;
  logic                 en;
  logic [ADC_W-1:0]     adc;
  logic [ADC_W-1:0]     zero;
  logic [ADC_W-1:0]     tare;

  assign en          = !valid_r || item_ready;
  assign in_ch.ready = en;
  assign item_valid  = valid_r;
  assign item        = item_r;

  assign adc  = in_ch.adc_average & ADC_MASK;
  assign zero = cfg.zero_level & ADC_MASK;
  assign tare = cfg.tare_level & ADC_MASK;

  // Form gross and net magnitudes, sign and gain range
  always_comb begin
    item_nxt.stable = in_ch.is_stable;
    if (adc > zero) begin
      item_nxt.gross_c = adc - zero;
      if (item_nxt.gross_c > tare) begin
        item_nxt.net_c    = NET_W'(item_nxt.gross_c - tare);
        item_nxt.positive = 1'b1;
      end else begin
        item_nxt.net_c    = NET_W'(tare - item_nxt.gross_c);
        item_nxt.positive = 1'b0;
      end
    end else begin
      item_nxt.gross_c  = zero - adc;
      item_nxt.net_c    = NET_W'(item_nxt.gross_c) + NET_W'(tare);
      item_nxt.positive = 1'b0;
    end
    item_nxt.use_high = !(item_nxt.gross_c < cfg.split_level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_ch.valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/swc_queue.sv
`default_nettype none

module swc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  input  wire swc_pkg::swc_item_t push_item,
  output logic                    push_ready,
  output logic                    pop_valid,
  output swc_pkg::swc_item_t      pop_item,
  input  wire logic               pop_ready
);
  import swc_pkg::*;

  swc_item_t   mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        push;
  logic        pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Store items
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/swc_back.sv
`default_nettype none

module swc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire swc_pkg::swc_cfg_t  cfg,
  input  wire logic               item_valid,
  input  wire swc_pkg::swc_item_t item,
  output logic                    item_ready,
  swc_out_if.source               out_ch
);
  import swc_pkg::*;

  // Stage 1: scaled weights
  logic                  v1_r;
  logic [GROSS_W_W-1:0]  gross_w1_r;
  logic [WT_W-1:0]       net_w1_r;
  logic                  pos1_r;
  logic                  stab1_r;

  // Stage 2: step quotient and limits
  logic                  v2_r;
  logic [WT_W-1:0]       w2_r;
  logic [V_W-1:0]        v2v_r;
  logic [Q_W-1:0]        q2_r;
  swc_step_t             kind2_r;
  logic                  below2_r;
  logic                  over2_r;
  logic [WT_W-1:0]       gross2_r;
  logic                  pos2_r;
  logic                  stab2_r;

  // Stage 3: output register
  logic                  v3_r;
  logic [WT_W-1:0]       gross3_r;
  logic [WT_W-1:0]       shown3_r;
  logic                  pos3_r;
  logic                  zero3_r;
  logic                  full3_r;

  logic en1;
  logic en2;
  logic en3;

  logic [GAIN_W-1:0]     gain;
  logic [GPROD_W-1:0]    gprod;
  logic [NPROD_W-1:0]    nprod;
  logic [NETW_W-1:0]     net_full;

  swc_step_t             kind;
  logic [STEP_W-1:0]     offs;
  logic [M_W-1:0]        recip;
  logic [V_W-1:0]        v;
  logic [QPROD_W-1:0]    qprod;
  logic [MIN_W+STEP_W-1:0] min_w;

  logic [STEP_W-1:0]     d3;
  logic [Q_W+STEP_W-1:0] qd;
  logic [V_W-1:0]        rem_full;
  logic [REM_W-1:0]      rem;
  logic [V_W-1:0]        base;
  logic                  up;
  logic [V_W-1:0]        shown;
  logic                  at_zero;
  logic                  positive;
  logic                  full;

  assign en3        = !v3_r || out_ch.ready;
  assign en2        = !v2_r || en3;
  assign en1        = !v1_r || en2;
  assign item_ready = en1;

  // Scale with round half up
  always_comb begin
    gain     = item.use_high ? cfg.gain_high : cfg.gain_low;
    gprod    = GPROD_W'(item.gross_c) * GPROD_W'(gain) + (GPROD_W'(1) << (FRAC_W - 1));
    nprod    = NPROD_W'(item.net_c) * NPROD_W'(gain) + (NPROD_W'(1) << (FRAC_W - 1));
    net_full = nprod[NPROD_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (en1 && item_valid) begin
      gross_w1_r <= gprod[GPROD_W-1:FRAC_W];
      net_w1_r   <= (|net_full[NETW_W-1:WT_W]) ? WT_MAX : net_full[WT_W-1:0];
      pos1_r     <= item.positive;
      stab1_r    <= item.stable;
    end
  end

  // Pick the step rule and take the quotient by reciprocal
  always_comb begin
    kind = step_decode(cfg.step_size);
    unique case (kind)
      STEP_10:  begin offs = 7'd5;  recip = RECIP_10;  end
      STEP_20:  begin offs = 7'd0;  recip = RECIP_20;  end
      STEP_50:  begin offs = 7'd5;  recip = RECIP_50;  end
      STEP_100: begin offs = 7'd50; recip = RECIP_100; end
      default:  begin offs = 7'd0;  recip = RECIP_5;   end
    endcase
    v     = V_W'(net_w1_r) + V_W'(offs);
    qprod = QPROD_W'(v) * QPROD_W'(recip);
    min_w = (MIN_W+STEP_W)'(cfg.display_min_steps) * (MIN_W+STEP_W)'(cfg.step_size);
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      w2_r     <= net_w1_r;
      v2v_r    <= v;
      q2_r     <= qprod[RECIP_SHIFT +: Q_W];
      kind2_r  <= kind;
      below2_r <= V_W'(net_w1_r) < V_W'(min_w);
      over2_r  <= gross_w1_r > GROSS_W_W'(cfg.overload_limit);
      gross2_r <= (|gross_w1_r[GROSS_W_W-1:WT_W]) ? WT_MAX : gross_w1_r[WT_W-1:0];
      pos2_r   <= pos1_r;
      stab2_r  <= stab1_r;
    end
  end

  // Remainder, step rounding and flags
  always_comb begin
    d3       = step_div(kind2_r);
    qd       = (Q_W+STEP_W)'(q2_r) * (Q_W+STEP_W)'(d3);
    rem_full = v2v_r - qd[V_W-1:0];
    rem      = rem_full[REM_W-1:0];
    base     = v2v_r - V_W'(rem);
    unique case (kind2_r)
      STEP_5:  up = rem >= 7'd3;
      STEP_20: up = rem >= 7'd10;
      STEP_50: up = rem >= 7'd30;
      default: up = 1'b0;
    endcase
    if (below2_r) begin
      shown = '0;
    end else begin
      unique case (kind2_r)
        STEP_PASS: shown = V_W'(w2_r);
        STEP_2:    shown = V_W'({w2_r[WT_W-1:1], 1'b0});
        default:   shown = base + (up ? V_W'(d3) : V_W'(0));
      endcase
    end
    at_zero  = stab2_r && (shown == '0);
    positive = pos2_r || at_zero;
    full     = positive ? over2_r : (shown > V_W'(NEG_FULL_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      gross3_r <= gross2_r;
      shown3_r <= (|shown[V_W-1:WT_W]) ? WT_MAX : shown[WT_W-1:0];
      pos3_r   <= positive;
      zero3_r  <= at_zero;
      full3_r  <= full;
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= item_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  assign out_ch.valid        = v3_r;
  assign out_ch.gross_weight = gross3_r;
  assign out_ch.shown_weight = shown3_r;
  assign out_ch.is_positive  = pos3_r;
  assign out_ch.at_zero      = zero3_r;
  assign out_ch.overloaded   = full3_r;

endmodule

`default_nettype wire

// File: hw/rtl/scale_weight_conversion_core.sv
`default_nettype none

// Channel   Direction  Handshake      Payload
// in_ch     sink       valid/ready    adc_average[23:0], is_stable
// out_ch    source     valid/ready    gross_weight[19:0], shown_weight[19:0],
//                                     is_positive, at_zero, overloaded
// cfg_ch    sink       valid/ready    addr[7:0], data[31:0] (ready always high)
//
// One item per cycle sustained while out_ch is ready. A result passes through the
// front register, the two-entry queue, then the scale, step quotient and output
// stages. The two gain multipliers set the scale stage.
// rst_n is synchronous; it empties the pipeline and loads register defaults.
// A stalled output backs up the back stages, then the queue, then in_ch.

module scale_weight_conversion_core (
  input  wire logic clk,
  input  wire logic rst_n,
  swc_in_if.sink    in_ch,
  swc_out_if.source out_ch,
  swc_cfg_if.sink   cfg_ch
);
  import swc_pkg::*;

  swc_cfg_t  cfg;
  logic      f_valid;
  swc_item_t f_item;
  logic      f_ready;
  logic      b_valid;
  swc_item_t b_item;
  logic      b_ready;

  swc_cfg_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  swc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  swc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_item  (f_item),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_item   (b_item),
    .pop_ready  (b_ready)
  );

  swc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (b_valid),
    .item       (b_item),
    .item_ready (b_ready),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
